FILE: hdl/qch_pkg.sv
`default_nettype none

package qch_pkg;

  localparam int TABLE_ENTRIES = 2048;
  localparam int COUNT_BITS    = 18;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int USED_W        = IDX_W + 1;
  localparam int COLOR_W       = 32;
  localparam int KIND_W        = 2;
  localparam int STEP_W        = 8;
  localparam int NUM_W         = 10;
  localparam int REM_W         = 9;
  localparam int CNT_W         = 4;
  localparam int PADDR_W       = 3;

  localparam logic [STEP_W-1:0]     QSTEP_RESET = 8'd24;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [CNT_W-1:0]      DIV_LAST    = 4'd9;
  localparam logic [USED_W-1:0]     USED_FULL   = USED_W'(TABLE_ENTRIES);

  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [0:0] REG_QUANT_STEP = 1'b0;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   read_index;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]      entry_index;
    logic                  is_new;
    logic                  dropped;
    logic [COLOR_W-1:0]    entry_color;
    logic [COUNT_BITS-1:0] entry_count;
    logic                  entry_valid;
    logic [USED_W-1:0]     entries_used;
    logic [COUNT_BITS-1:0] total_pixels;
  } res_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_READ
  } back_state_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/qch_in_if.sv
`default_nettype none

interface qch_in_if;
  logic                         valid;
  logic                         ready;
  logic [qch_pkg::KIND_W-1:0]   kind;
  logic [qch_pkg::COLOR_W-1:0]  pixel_argb;
  logic [qch_pkg::IDX_W-1:0]    read_index;

  modport source (output valid, kind, pixel_argb, read_index, input ready);
  modport sink   (input valid, kind, pixel_argb, read_index, output ready);
endinterface

`default_nettype wire

FILE: hdl/qch_out_if.sv
`default_nettype none

interface qch_out_if;
  logic                           valid;
  logic                           ready;
  logic [qch_pkg::IDX_W-1:0]      entry_index;
  logic                           is_new;
  logic                           dropped;
  logic [qch_pkg::COLOR_W-1:0]    entry_color;
  logic [qch_pkg::COUNT_BITS-1:0] entry_count;
  logic                           entry_valid;
  logic [qch_pkg::USED_W-1:0]     entries_used;
  logic [qch_pkg::COUNT_BITS-1:0] total_pixels;

  modport source (output valid, entry_index, is_new, dropped, entry_color, entry_count,
                  entry_valid, entries_used, total_pixels, input ready);
  modport sink   (input valid, entry_index, is_new, dropped, entry_color, entry_count,
                  entry_valid, entries_used, total_pixels, output ready);
endinterface

`default_nettype wire

FILE: hdl/quantized_color_histogram.sv
// Colour histogram of a pixel stream. Each request is a pixel, a read of one
// table entry, or a clear of the table and total; each gives one result, while a
// request of the unused kind is dropped with none. A front end takes one request
// at a time and, when the step is above one, quantizes the pixel with a
// bit-serial divider and then a multiply. A two-deep queue feeds the back end,
// which searches the colour table held in block memory one stored entry per
// cycle. The table needs no clearing pass: the fill count marks which entries
// hold data. quant_step sits at byte address 0 of the APB port and resets
// to 24.
`default_nettype none

module quantized_color_histogram (
  input  wire logic                         clk,
  input  wire logic                         rst,
  qch_in_if.sink                            in_ch,
  qch_out_if.source                         out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [qch_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [qch_pkg::STEP_W-1:0] quant_step;
  logic                       push_valid, push_ready, pop_valid, pop_ready;
  qch_pkg::req_t              push_data, pop_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == qch_pkg::REG_QUANT_STEP) ? {24'd0, quant_step} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      quant_step <= qch_pkg::QSTEP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == qch_pkg::REG_QUANT_STEP) begin
      quant_step <= pwdata[7:0];
    end
  end

  qch_front u_front (
    .clk        (clk),
    .rst        (rst),
    .quant_step (quant_step),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  qch_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  qch_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

FILE: hdl/qch_front.sv
`default_nettype none

module qch_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [qch_pkg::STEP_W-1:0]  quant_step,
  qch_in_if.sink                           in_ch,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output qch_pkg::req_t                    push_data
);

  qch_pkg::front_state_t state, state_next;
  qch_pkg::req_t         req, req_next;
  logic [qch_pkg::REM_W-1:0] rem [3];
  logic [qch_pkg::REM_W-1:0] rem_next [3];
  logic [qch_pkg::NUM_W-1:0] num [3];
  logic [qch_pkg::NUM_W-1:0] num_next [3];
  logic [qch_pkg::CNT_W-1:0] cnt, cnt_next;

  logic [qch_pkg::REM_W-1:0] dvs;
  logic                      quantize;
  logic [qch_pkg::NUM_W-1:0] trial [3];
  logic [17:0]               prod [3];
  logic [7:0]                qch [3];
  logic [7:0]                chan_in [3];

  assign dvs      = {quant_step, 1'b0};
  assign quantize = (quant_step > 8'd1);
  assign chan_in[0] = in_ch.pixel_argb[7:0];
  assign chan_in[1] = in_ch.pixel_argb[15:8];
  assign chan_in[2] = in_ch.pixel_argb[23:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qch_pkg::F_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
    req <= req_next;
    for (int i = 0; i < 3; i++) begin
      rem[i] <= rem_next[i];
      num[i] <= num_next[i];
    end
  end

  always_comb begin
    state_next  = state;
    req_next    = req;
    cnt_next    = cnt;
    in_ch.ready = 1'b0;
    push_valid  = 1'b0;
    push_data   = req;
    for (int i = 0; i < 3; i++) begin
      rem_next[i] = rem[i];
      num_next[i] = num[i];
      trial[i]    = {rem[i], num[i][qch_pkg::NUM_W-1]};
      prod[i]     = 18'(num[i]) * 18'(quant_step);
      qch[i]      = (prod[i] > 18'd255) ? 8'hFF : prod[i][7:0];
    end

    unique case (state)
      qch_pkg::F_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          req_next.kind       = in_ch.kind;
          req_next.color      = in_ch.pixel_argb;
          req_next.read_index = in_ch.read_index;
          case (in_ch.kind)
            qch_pkg::KIND_PIXEL: begin
              if (quantize) begin
                for (int i = 0; i < 3; i++) begin
                  rem_next[i] = '0;
                  num_next[i] = {1'b0, chan_in[i], 1'b0} + {2'b00, quant_step} - 10'd2;
                end
                cnt_next   = '0;
                state_next = qch_pkg::F_DIV;
              end else begin
                state_next = qch_pkg::F_PUSH;
              end
            end
            qch_pkg::KIND_READ, qch_pkg::KIND_CLEAR: state_next = qch_pkg::F_PUSH;
            default: state_next = qch_pkg::F_IDLE;
          endcase
        end
      end
      qch_pkg::F_DIV: begin
        // Restoring division, one quotient bit per channel each cycle.
        for (int i = 0; i < 3; i++) begin
          if (trial[i] >= {1'b0, dvs}) begin
            rem_next[i] = qch_pkg::REM_W'(trial[i] - {1'b0, dvs});
            num_next[i] = {num[i][qch_pkg::NUM_W-2:0], 1'b1};
          end else begin
            rem_next[i] = trial[i][qch_pkg::REM_W-1:0];
            num_next[i] = {num[i][qch_pkg::NUM_W-2:0], 1'b0};
          end
        end
        cnt_next = cnt + 1'b1;
        if (cnt == qch_pkg::DIV_LAST) state_next = qch_pkg::F_MUL;
      end
      qch_pkg::F_MUL: begin
        req_next.color = {8'hFF, qch[2], qch[1], qch[0]};
        state_next     = qch_pkg::F_PUSH;
      end
      qch_pkg::F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) state_next = qch_pkg::F_IDLE;
      end
      default: state_next = qch_pkg::F_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/qch_queue.sv
`default_nettype none

module qch_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire qch_pkg::req_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output qch_pkg::req_t      pop_data
);

  qch_pkg::req_t slots [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    fill;
  logic          do_push, do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

FILE: hdl/qch_back.sv
`default_nettype none

module qch_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pop_valid,
  output logic               pop_ready,
  input  wire qch_pkg::req_t pop_data,
  qch_out_if.source          out_ch
);

  localparam int IW = qch_pkg::IDX_W;
  localparam int UW = qch_pkg::USED_W;
  localparam int CB = qch_pkg::COUNT_BITS;

  logic [qch_pkg::COLOR_W-1:0] color_mem [qch_pkg::TABLE_ENTRIES];
  logic [CB-1:0]               count_mem [qch_pkg::TABLE_ENTRIES];
  logic [qch_pkg::COLOR_W-1:0] color_q;
  logic [CB-1:0]               count_q;

  qch_pkg::back_state_t state, state_next;
  qch_pkg::req_t        req, req_next;
  qch_pkg::res_t        res, res_next;
  logic                 out_valid, out_valid_next;
  logic [UW-1:0]        used, used_next;
  logic [CB-1:0]        total, total_next;
  logic [UW-1:0]        scan_addr, scan_addr_next;
  logic                 rd_pend, rd_pend_next;
  logic [IW-1:0]        rd_idx, rd_idx_next;

  logic [IW-1:0]                mem_ra;
  logic                         color_we, count_we;
  logic [IW-1:0]                mem_wa;
  logic [qch_pkg::COLOR_W-1:0]  color_wd;
  logic [CB-1:0]                count_wd;
  logic [CB-1:0]                count_inc;

  always_ff @(posedge clk) begin
    if (color_we) color_mem[mem_wa] <= color_wd;
    if (count_we) count_mem[mem_wa] <= count_wd;
    color_q <= color_mem[mem_ra];
    count_q <= count_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qch_pkg::B_IDLE;
      out_valid <= 1'b0;
      used      <= '0;
      total     <= '0;
      rd_pend   <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      used      <= used_next;
      total     <= total_next;
      rd_pend   <= rd_pend_next;
    end
    req       <= req_next;
    res       <= res_next;
    scan_addr <= scan_addr_next;
    rd_idx    <= rd_idx_next;
  end

  assign count_inc = qch_pkg::sat_inc(count_q);

  always_comb begin
    state_next     = state;
    req_next       = req;
    res_next       = res;
    out_valid_next = out_valid && !out_ch.ready;
    used_next      = used;
    total_next     = total;
    scan_addr_next = scan_addr;
    rd_pend_next   = rd_pend;
    rd_idx_next    = rd_idx;
    mem_ra         = rd_idx;
    color_we       = 1'b0;
    count_we       = 1'b0;
    mem_wa         = rd_idx;
    color_wd       = req.color;
    count_wd       = count_inc;
    pop_ready      = 1'b0;

    unique case (state)
      qch_pkg::B_IDLE: begin
        pop_ready = !out_valid;
        if (pop_valid && !out_valid) begin
          req_next = pop_data;
          res_next = '0;
          case (pop_data.kind)
            qch_pkg::KIND_PIXEL: begin
              total_next     = qch_pkg::sat_inc(total);
              scan_addr_next = '0;
              rd_pend_next   = 1'b0;
              state_next     = qch_pkg::B_SCAN;
            end
            qch_pkg::KIND_READ: begin
              if ({1'b0, pop_data.read_index} < used) begin
                mem_ra     = pop_data.read_index;
                state_next = qch_pkg::B_READ;
              end else begin
                res_next.entry_index  = pop_data.read_index;
                res_next.entries_used = used;
                res_next.total_pixels = total;
                out_valid_next        = 1'b1;
              end
            end
            qch_pkg::KIND_CLEAR: begin
              used_next      = '0;
              total_next     = '0;
              out_valid_next = 1'b1;
            end
            default: state_next = qch_pkg::B_IDLE;
          endcase
        end
      end
      qch_pkg::B_SCAN: begin
        // Reads are issued one a cycle; each is compared in the cycle after it is issued.
        if (rd_pend && color_q == req.color) begin
          count_we              = 1'b1;
          mem_wa                = rd_idx;
          count_wd              = count_inc;
          res_next.entry_index  = rd_idx;
          res_next.entry_color  = req.color;
          res_next.entry_count  = count_inc;
          res_next.entry_valid  = 1'b1;
          res_next.entries_used = used;
          res_next.total_pixels = total;
          out_valid_next        = 1'b1;
          rd_pend_next          = 1'b0;
          state_next            = qch_pkg::B_IDLE;
        end else if (scan_addr < used) begin
          mem_ra         = scan_addr[IW-1:0];
          rd_idx_next    = scan_addr[IW-1:0];
          rd_pend_next   = 1'b1;
          scan_addr_next = scan_addr + 1'b1;
        end else if (rd_pend) begin
          rd_pend_next = 1'b0;
        end else begin
          res_next.entry_color  = req.color;
          res_next.total_pixels = total;
          if (used < qch_pkg::USED_FULL) begin
            color_we              = 1'b1;
            count_we              = 1'b1;
            mem_wa                = used[IW-1:0];
            color_wd              = req.color;
            count_wd              = CB'(1);
            used_next             = used + 1'b1;
            res_next.entry_index  = used[IW-1:0];
            res_next.is_new       = 1'b1;
            res_next.entry_count  = CB'(1);
            res_next.entry_valid  = 1'b1;
            res_next.entries_used = used + 1'b1;
          end else begin
            res_next.dropped      = 1'b1;
            res_next.entries_used = used;
          end
          out_valid_next = 1'b1;
          state_next     = qch_pkg::B_IDLE;
        end
      end
      qch_pkg::B_READ: begin
        res_next.entry_index  = req.read_index;
        res_next.entry_color  = color_q;
        res_next.entry_count  = count_q;
        res_next.entry_valid  = 1'b1;
        res_next.entries_used = used;
        res_next.total_pixels = total;
        out_valid_next        = 1'b1;
        state_next            = qch_pkg::B_IDLE;
      end
      default: state_next = qch_pkg::B_IDLE;
    endcase
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.entry_index  = res.entry_index;
  assign out_ch.is_new       = res.is_new;
  assign out_ch.dropped      = res.dropped;
  assign out_ch.entry_color  = res.entry_color;
  assign out_ch.entry_count  = res.entry_count;
  assign out_ch.entry_valid  = res.entry_valid;
  assign out_ch.entries_used = res.entries_used;
  assign out_ch.total_pixels = res.total_pixels;

endmodule

`default_nettype wire

FILE: hdl/qch_checker.sv
`default_nettype none

module qch_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [qch_pkg::IDX_W-1:0]      entry_index,
  input wire logic                           is_new,
  input wire logic                           dropped,
  input wire logic [qch_pkg::COUNT_BITS-1:0] entry_count,
  input wire logic                           entry_valid,
  input wire logic [qch_pkg::USED_W-1:0]     entries_used
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry_index) && $stable(entry_count))
    else $error("result changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_new && dropped))
    else $error("result both new and dropped");

  a_new: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_new |-> entry_valid && entry_count == 18'd1 &&
                            {1'b0, entry_index} == entries_used - 12'd1)
    else $error("new entry not the last one used");

  a_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> !entry_valid && entries_used == qch_pkg::USED_FULL)
    else $error("drop while table not full");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_valid |-> {1'b0, entry_index} < entries_used)
    else $error("valid entry beyond used entries");

endmodule

bind quantized_color_histogram qch_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .entry_index  (out_ch.entry_index),
  .is_new       (out_ch.is_new),
  .dropped      (out_ch.dropped),
  .entry_count  (out_ch.entry_count),
  .entry_valid  (out_ch.entry_valid),
  .entries_used (out_ch.entries_used)
);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [qch_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  qch_in_if  in_ch ();
  qch_out_if out_ch ();

  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [qch_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  quantized_color_histogram uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state.
  logic [qch_pkg::COLOR_W-1:0]    hist_color [qch_pkg::TABLE_ENTRIES];
  logic [qch_pkg::COUNT_BITS-1:0] hist_count [qch_pkg::TABLE_ENTRIES];
  int unsigned                    hist_used;
  logic [qch_pkg::COUNT_BITS-1:0] hist_total;
  logic [qch_pkg::STEP_W-1:0]     hist_step;

  qch_pkg::res_t pending_results[$];
  int            errors = 0;
  int            idle_cycles = 0;
  bit            hold_long = 1'b0;

  function automatic logic [7:0] quant_chan(input logic [7:0] c, input logic [7:0] s);
    int unsigned q;
    q = ((2 * c + s - 2) / (2 * s)) * s;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic logic [31:0] quant_pixel(input logic [31:0] p, input logic [7:0] s);
    if (s <= 1) return p;
    return {8'hFF, quant_chan(p[23:16], s), quant_chan(p[15:8], s), quant_chan(p[7:0], s)};
  endfunction

  function automatic logic [qch_pkg::COUNT_BITS-1:0] bump(
    input logic [qch_pkg::COUNT_BITS-1:0] v);
    return (v == qch_pkg::COUNT_MAX) ? qch_pkg::COUNT_MAX : v + 1'b1;
  endfunction

  function automatic qch_pkg::res_t histogram_step(input qch_pkg::req_t r);
    qch_pkg::res_t o;
    int            i;
    bit            hit;
    o = '0;
    hit = 1'b0;
    if (r.kind == qch_pkg::KIND_PIXEL) begin
      o.entry_color = quant_pixel(r.color, hist_step);
      hist_total = bump(hist_total);
      for (i = 0; i < hist_used; i++) begin
        if (hist_color[i] == o.entry_color) begin
          hit = 1'b1;
          break;
        end
      end
      if (hit) begin
        hist_count[i] = bump(hist_count[i]);
        o.entry_index = i[qch_pkg::IDX_W-1:0];
        o.entry_count = hist_count[i];
        o.entry_valid = 1'b1;
      end else if (hist_used < qch_pkg::TABLE_ENTRIES) begin
        o.entry_index = hist_used[qch_pkg::IDX_W-1:0];
        hist_color[hist_used] = o.entry_color;
        hist_count[hist_used] = qch_pkg::COUNT_BITS'(1);
        o.entry_count = qch_pkg::COUNT_BITS'(1);
        hist_used++;
        o.is_new = 1'b1;
        o.entry_valid = 1'b1;
      end else begin
        o.dropped = 1'b1;
      end
    end else if (r.kind == qch_pkg::KIND_READ) begin
      o.entry_index = r.read_index;
      if (r.read_index < hist_used) begin
        o.entry_color = hist_color[r.read_index];
        o.entry_count = hist_count[r.read_index];
        o.entry_valid = 1'b1;
      end
    end else begin
      hist_used = 0;
      hist_total = '0;
    end
    o.entries_used = hist_used[qch_pkg::USED_W-1:0];
    o.total_pixels = hist_total;
    return o;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("tb: mismatch %s got %0h want %0h", what, got, want);
    errors++;
  endtask

  // Receiver: random stall pattern plus an optional long hold-off.
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else if (hold_long) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 7) != 0) || ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    qch_pkg::res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 64'd0, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.entry_index !== want.entry_index)
          report("entry_index", 64'(out_ch.entry_index), 64'(want.entry_index));
        if (out_ch.is_new !== want.is_new)
          report("is_new", 64'(out_ch.is_new), 64'(want.is_new));
        if (out_ch.dropped !== want.dropped)
          report("dropped", 64'(out_ch.dropped), 64'(want.dropped));
        if (out_ch.entry_color !== want.entry_color)
          report("entry_color", 64'(out_ch.entry_color), 64'(want.entry_color));
        if (out_ch.entry_count !== want.entry_count)
          report("entry_count", 64'(out_ch.entry_count), 64'(want.entry_count));
        if (out_ch.entry_valid !== want.entry_valid)
          report("entry_valid", 64'(out_ch.entry_valid), 64'(want.entry_valid));
        if (out_ch.entries_used !== want.entries_used)
          report("entries_used", 64'(out_ch.entries_used), 64'(want.entries_used));
        if (out_ch.total_pixels !== want.total_pixels)
          report("total_pixels", 64'(out_ch.total_pixels), 64'(want.total_pixels));
      end
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic apb_write(input logic [qch_pkg::PADDR_W-1:0] a, input logic [31:0] d);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_step(input logic [7:0] s);
    wait_drained();
    apb_write({qch_pkg::REG_QUANT_STEP, 2'b00}, {24'd0, s});
    hist_step = s;
  endtask

  // Sends one request and, if its kind gives a result, records the predicted result once it is accepted.
  task automatic send(input qch_pkg::req_t r, input bit gap);
    qch_pkg::res_t want;
    if (gap && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= r.kind;
    in_ch.pixel_argb <= r.color;
    in_ch.read_index <= r.read_index;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (r.kind != KIND_UNUSED) begin
      want = histogram_step(r);
      pending_results.push_back(want);
    end
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pixel(input int palette);
    logic [31:0] p;
    p = $urandom();
    if (palette > 0) p = {p[31:24], 8'(p[23:16] % palette), 8'(p[15:8] % palette),
                          8'(p[7:0] % palette)};
    return p;
  endfunction

  typedef struct {
    qch_pkg::req_t r;
    bit            typed;
    qch_pkg::res_t want;
  } row_t;

  row_t rows[$];

  task automatic add_row(input logic [1:0] k, input logic [31:0] c, input logic [10:0] ix,
                         input bit typed, input qch_pkg::res_t w);
    row_t x;
    x.r.kind = k; x.r.color = c; x.r.read_index = ix; x.typed = typed; x.want = w;
    rows.push_back(x);
  endtask

  initial begin
    qch_pkg::res_t w;
    qch_pkg::req_t r;
    int            n;
    int            i;
    in_ch.valid <= 1'b0;
    in_ch.kind <= '0;
    in_ch.pixel_argb <= '0;
    in_ch.read_index <= '0;
    hist_used = 0;
    hist_total = '0;
    hist_step = qch_pkg::QSTEP_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; typed results where they are plain to see.
    w = '0;
    add_row(qch_pkg::KIND_READ, '0, '0, 1'b1, w);
    add_row(qch_pkg::KIND_READ, '0, 11'h7FF, 1'b1, '{default: '0, entry_index: 11'h7FF});
    add_row(qch_pkg::KIND_PIXEL, 32'h0000_0000, '0, 1'b1,
            '{entry_index: 11'd0, is_new: 1'b1, dropped: 1'b0, entry_color: 32'hFF00_0000,
              entry_count: 18'd1, entry_valid: 1'b1, entries_used: 12'd1,
              total_pixels: 18'd1});
    add_row(qch_pkg::KIND_PIXEL, 32'hFFFF_FFFF, '0, 1'b0, w);
    add_row(qch_pkg::KIND_PIXEL, 32'h0101_0101, '0, 1'b0, w);
    add_row(qch_pkg::KIND_PIXEL, 32'h12AB_CD34, '0, 1'b0, w);
    add_row(qch_pkg::KIND_READ, '0, 11'd1, 1'b0, w);
    add_row(qch_pkg::KIND_READ, '0, 11'd2, 1'b0, w);
    add_row(KIND_UNUSED, 32'hDEAD_BEEF, 11'd5, 1'b0, w);
    add_row(qch_pkg::KIND_CLEAR, '0, '0, 1'b1, w);
    add_row(qch_pkg::KIND_READ, '0, '0, 1'b1, w);
    foreach (rows[j]) begin
      send(rows[j].r, 1'b0);
      if (rows[j].typed && pending_results[$] !== rows[j].want) begin
        report("directed row", 64'(pending_results[$]), 64'(rows[j].want));
        void'(pending_results.pop_back());
        pending_results.push_back(rows[j].want);
      end
    end
    stop_sending();

    // Step extremes: 1 (raw), 255, 0 (treated as 1).
    set_step(8'd1);
    r.kind = qch_pkg::KIND_PIXEL; r.read_index = '0;
    r.color = 32'h00FF_7F01; send(r, 1'b0);
    r.color = 32'h00FF_7F01; send(r, 1'b0);
    r.kind = qch_pkg::KIND_READ; send(r, 1'b0);
    stop_sending();
    set_step(8'd255);
    r.kind = qch_pkg::KIND_PIXEL;
    r.color = 32'h55FF_8080; send(r, 1'b0);
    r.color = 32'h007F_7F7F; send(r, 1'b0);
    stop_sending();
    set_step(8'd0);
    r.color = 32'hA5A5_A5A5; send(r, 1'b0);
    stop_sending();

    // Pressure: long receiver hold-off while the sender keeps offering.
    set_step(8'd16);
    hold_long = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_long = 1'b0;
      end
      begin
        for (i = 0; i < 30; i++) begin
          r.kind = qch_pkg::KIND_PIXEL; r.color = rand_pixel(64); send(r, 1'b0);
        end
        stop_sending();
      end
    join
    wait_drained();

    // Random phases with varied steps; a small palette in one phase for repeated hits.
    for (n = 0; n < 6; n++) begin
      case (n)
        0: set_step(8'd24);
        1: set_step(8'd1);
        2: set_step(8'd255);
        3: set_step(8'($urandom_range(2, 254)));
        4: set_step(8'd3);
        default: set_step(8'd64);
      endcase
      for (i = 0; i < 15; i++) begin
        r.read_index = qch_pkg::IDX_W'($urandom_range(0, 63));
        if ($urandom_range(0, 9) == 0) r.read_index = qch_pkg::IDX_W'($urandom());
        r.color = rand_pixel((n == 1) ? 4 : 0);
        case ($urandom_range(0, 39))
          0: r.kind = qch_pkg::KIND_CLEAR;
          1: r.kind = KIND_UNUSED;
          2, 3, 4, 5, 6: r.kind = qch_pkg::KIND_READ;
          default: r.kind = qch_pkg::KIND_PIXEL;
        endcase
        send(r, 1'b1);
      end
      stop_sending();
    end

    // Fill the table to capacity and beyond with raw colours, then read back.
    set_step(8'd1);
    r.kind = qch_pkg::KIND_CLEAR; send(r, 1'b0);
    for (i = 0; i < qch_pkg::TABLE_ENTRIES + 8; i++) begin
      r.kind = qch_pkg::KIND_PIXEL; r.color = 32'(i); send(r, 1'b0);
    end
    r.color = 32'd5; send(r, 1'b0);
    r.kind = qch_pkg::KIND_READ; r.read_index = 11'h7FF; send(r, 1'b0);
    r.read_index = '0; send(r, 1'b0);
    stop_sending();

    wait_drained();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

FILE: sim.f
hdl/qch_pkg.sv
hdl/qch_in_if.sv
hdl/qch_out_if.sv
hdl/qch_front.sv
hdl/qch_queue.sv
hdl/qch_back.sv
hdl/quantized_color_histogram.sv
hdl/qch_checker.sv
tb/tb.sv
